### rtl/core/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted priority queue cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  localparam int unsigned KeyW    = 32;
  localparam int unsigned OpW     = 2;
  localparam int unsigned StatusW = 2;
  localparam int unsigned PosW    = 4;
  localparam int unsigned CountW  = 5;
  localparam int unsigned InDataW  = 40;  // 34 bits of fields, padded to bytes
  localparam int unsigned OutDataW = 48;  // 44 bits of fields, padded to bytes

  typedef enum logic [OpW-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FIND   = 2'd2
  } opcode_e;

  typedef enum logic [StatusW-1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } fsm_e;

  typedef enum logic [1:0] {
    SH_HOLD,
    SH_INSERT,
    SH_REMOVE
  } shift_e;

  // lt: occupied and entry < key; le: occupied and entry <= key
  typedef struct packed {
    logic lt;
    logic le;
  } cell_flags_t;

  typedef struct packed {
    logic   cmp_en;
    shift_e shift;
  } cell_cmd_t;

endpackage

`default_nettype wire

### rtl/core/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded ascending queue of signed values held in a chain of cells.
// ----------------------------------------------------------------------------
// Accepting a request loads the compare flags in every cell; the execute
// state then shifts the chain and registers the result. No new request is
// accepted until the execute state is done.
// A stalled output holds the chain in the execute state until taken.
// Reset empties the queue (count zero); entry contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // [1:0] opcode, [33:2] key_value, [39:34] zero
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // [1:0] status, [5:2] match_position, [37:6] head_value,
  // [38] is_empty, [43:39] entry_count, [47:44] zero
  output logic [OutDataW-1:0]      m_axis_tdata_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = $clog2(CAPACITY);

  fsm_e                   state_q, state_d;
  logic [OpW-1:0]         op_q;
  logic signed [KeyW-1:0] key_q;
  logic [CW-1:0]          count_q, count_d;
  logic                   m_valid_q;
  logic [OutDataW-1:0]    m_data_q, m_data_d;

  logic                   in_acc, out_free, exec_go;
  logic signed [KeyW-1:0] in_key;
  cell_cmd_t              cmd;
  logic [CAPACITY-1:0]    lt_vec, le_vec;
  logic signed [KeyW-1:0] vals [CAPACITY];
  cell_flags_t            flags [CAPACITY];
  logic                   found, full, do_ins, do_del;
  logic [PW-1:0]          pos;
  status_e                status;
  logic [PosW-1:0]        pos_out;
  logic signed [KeyW-1:0] head;

  assign in_key   = s_axis_tdata_i[OpW +: KeyW];
  assign out_free = !m_valid_q || m_axis_tready_i;

  always_comb begin
    state_d         = state_q;
    s_axis_tready_o = 1'b0;
    exec_go         = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          exec_go = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= s_axis_tdata_i[OpW-1:0];
      key_q <= in_key;
    end
  end

  // Cell chain
  assign cmd.cmp_en = in_acc;
  assign cmd.shift  = !exec_go ? SH_HOLD :
                      do_ins   ? SH_INSERT :
                      do_del   ? SH_REMOVE : SH_HOLD;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    cell_flags_t            lf;
    logic signed [KeyW-1:0] lv, rv;

    if (g == 0) begin : g_first
      assign lf = '{lt: 1'b1, le: 1'b1};
      assign lv = key_q;
    end else begin : g_mid
      assign lf = flags[g-1];
      assign lv = vals[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign rv = vals[g];
    end else begin : g_inner
      assign rv = vals[g+1];
    end

    spq_cell #(
      .Idx (g),
      .CW  (CW)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .cmp_key_i    (in_key),
      .ins_key_i    (key_q),
      .count_i      (count_q),
      .left_flags_i (lf),
      .left_val_i   (lv),
      .right_val_i  (rv),
      .flags_o      (flags[g]),
      .val_o        (vals[g])
    );

    assign lt_vec[g] = flags[g].lt;
    assign le_vec[g] = flags[g].le;
  end

  spq_match #(
    .N  (CAPACITY),
    .PW (PW)
  ) u_match (
    .lt_i    (lt_vec),
    .le_i    (le_vec),
    .found_o (found),
    .pos_o   (pos)
  );

  // Result and count update
  assign full = count_q == CW'(CAPACITY);

  always_comb begin
    do_ins  = 1'b0;
    do_del  = 1'b0;
    status  = ST_NOT_FOUND;
    pos_out = '0;
    unique case (op_q)
      OP_INSERT: begin
        do_ins = !full;
        status = full ? ST_FULL : ST_DONE;
      end
      OP_REMOVE: begin
        do_del = found;
        status = found ? ST_DONE : ST_NOT_FOUND;
      end
      OP_FIND: begin
        status = found ? ST_DONE : ST_NOT_FOUND;
        if (found) pos_out = PosW'(pos);
      end
      default: status = ST_NOT_FOUND;
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (do_ins) count_d = count_q + CW'(1);
    else if (do_del) count_d = count_q - CW'(1);
  end

  // head after the shift, taken from the first two cells or the inserted key
  always_comb begin
    if (count_d == '0) head = '0;
    else if (do_ins) head = flags[0].le ? vals[0] : key_q;
    else if (do_del) head = flags[0].lt ? vals[0] : vals[1];
    else head = vals[0];
  end

  always_comb begin
    m_data_d = '0;
    m_data_d[StatusW-1:0]           = status;
    m_data_d[StatusW +: PosW]       = pos_out;
    m_data_d[StatusW+PosW +: KeyW]  = head;
    m_data_d[StatusW+PosW+KeyW]     = count_d == '0;
    m_data_d[StatusW+PosW+KeyW+1 +: CountW] = CountW'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (exec_go) count_q <= count_d;
      if (exec_go) m_valid_q <= 1'b1;
      else if (m_axis_tready_i) m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_go) m_data_q <= m_data_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // Assertions
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_count_on_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !exec_go |=> $stable(count_q))
    else $error("count changed outside an execute cycle");

  a_sorted_flags : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EXEC |->
      (((lt_vec >> 1) & ~lt_vec) == '0) && (((le_vec >> 1) & ~le_vec) == '0))
    else $error("compare flags not monotone, chain out of order");

  a_empty_head : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[StatusW+PosW+KeyW] |->
      m_axis_tdata_o[StatusW+PosW +: KeyW] == '0)
    else $error("non-zero head reported for empty queue");

endmodule

`default_nettype wire

### rtl/core/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry, compares it with the key
// and moves it to or takes it from a neighbour on insert or remove.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell
  import spq_pkg::*;
#(
  parameter int unsigned Idx = 0,
  parameter int unsigned CW  = 5
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire cell_cmd_t              cmd_i,
  input  wire logic signed [KeyW-1:0] cmp_key_i,
  input  wire logic signed [KeyW-1:0] ins_key_i,
  input  wire logic [CW-1:0]          count_i,
  input  wire cell_flags_t            left_flags_i,
  input  wire logic signed [KeyW-1:0] left_val_i,
  input  wire logic signed [KeyW-1:0] right_val_i,
  output cell_flags_t                 flags_o,
  output logic signed [KeyW-1:0]      val_o
);

  logic signed [KeyW-1:0] val_q, val_d;
  cell_flags_t            flags_q, flags_d;
  logic                   occ;

  assign occ = count_i > CW'(Idx);

  always_comb begin
    flags_d = flags_q;
    if (cmd_i.cmp_en) begin
      flags_d.lt = occ && (val_q <  cmp_key_i);
      flags_d.le = occ && (val_q <= cmp_key_i);
    end
  end

  always_comb begin
    val_d = val_q;
    case (cmd_i.shift)
      SH_INSERT: begin
        // entries above the insertion point move up by one
        if (!flags_q.le) begin
          val_d = left_flags_i.le ? ins_key_i : left_val_i;
        end
      end
      SH_REMOVE: begin
        if (!flags_q.lt) val_d = right_val_i;
      end
      default: val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else begin
      flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign flags_o = flags_q;
  assign val_o   = val_q;

endmodule

`default_nettype wire

### rtl/core/spq_match.sv
// ----------------------------------------------------------------------------
// spq_match
// Collects the cell flags: whether the key is present and the position of
// its first occurrence.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_match
  import spq_pkg::*;
#(
  parameter int unsigned N  = 16,
  parameter int unsigned PW = 4
) (
  input  wire logic [N-1:0]  lt_i,
  input  wire logic [N-1:0]  le_i,
  output logic               found_o,
  output logic [PW-1:0]      pos_o
);

  logic [N-1:0] boundary;

  assign found_o = |(le_i & ~lt_i);

  // flags are a thermometer, so at most one cell sits at the lower bound
  always_comb begin
    pos_o = '0;
    for (int i = 0; i < N; i++) begin
      boundary[i] = !lt_i[i] && ((i == 0) || lt_i[(i == 0) ? 0 : i - 1]);
      if (boundary[i]) pos_o = pos_o | PW'(i);
    end
  end

endmodule

`default_nettype wire

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Streaming testbench for the sorted priority queue. A scoreboard keeps its
// own sorted copy of the queue, predicts status, match position, head, empty
// flag and count for each accepted request, and checks every result in
// order. Directed corner cases come first, then random runs that swing
// between filling and draining the queue under several idle/stall mixes.
// ----------------------------------------------------------------------------

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned PhaseItems = 200;
  localparam int unsigned RunLength  = 40;    // items per fill or drain run
  localparam logic [OpW-1:0] OP_UNUSED = 2'd3;
  localparam logic [KeyW-1:0] KeyPool [8] = '{
    32'h8000_0000, 32'h8000_0001, 32'hFFFF_FFFF, 32'h0000_0000,
    32'h0000_0001, 32'h7FFF_FFFE, 32'h7FFF_FFFF, 32'h0000_0064
  };

  typedef struct {
    status_e                   status;
    logic [PosW-1:0]           pos;
    logic signed [KeyW-1:0]    head;
    logic                      empty;
    logic [CountW-1:0]         count;
  } queue_result_t;

  class spq_scoreboard;
    logic signed [KeyW-1:0] store[$];
    queue_result_t          expected[$];
    int                     failures = 0;

    // first index whose entry is not below the key
    function int first_not_below(logic signed [KeyW-1:0] key);
      int idx;
      idx = 0;
      while (idx < store.size() && store[idx] < key) idx++;
      return idx;
    endfunction

    function void note_request(logic [OpW-1:0] op, logic signed [KeyW-1:0] key);
      queue_result_t r;
      int            idx;
      r.status = ST_NOT_FOUND;
      r.pos    = '0;
      case (op)
        OP_INSERT: begin
          if (store.size() >= QueueDepth) begin
            r.status = ST_FULL;
          end else begin
            // new entry goes after any equal ones
            idx = 0;
            while (idx < store.size() && store[idx] <= key) idx++;
            store.insert(idx, key);
            r.status = ST_DONE;
          end
        end
        OP_REMOVE: begin
          idx = first_not_below(key);
          if (idx < store.size() && store[idx] == key) begin
            store.delete(idx);
            r.status = ST_DONE;
          end
        end
        OP_FIND: begin
          idx = first_not_below(key);
          if (idx < store.size() && store[idx] == key) begin
            r.status = ST_DONE;
            r.pos    = idx[PosW-1:0];
          end
        end
        default: ;
      endcase
      r.head  = (store.size() != 0) ? store[0] : '0;
      r.empty = (store.size() == 0);
      r.count = CountW'(store.size());
      expected.push_back(r);
    endfunction

    function void check_result(logic [OutDataW-1:0] td);
      queue_result_t got;
      queue_result_t want;
      got.status = status_e'(td[1:0]);
      got.pos    = td[5:2];
      got.head   = td[37:6];
      got.empty  = td[38];
      got.count  = td[43:39];
      if (expected.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("%0t: unexpected result st=%0d pos=%0d head=%0d empty=%0b cnt=%0d",
                   $realtime, got.status, got.pos, got.head, got.empty, got.count);
        return;
      end
      want = expected.pop_front();
      if (got.status !== want.status || got.pos !== want.pos || got.head !== want.head ||
          got.empty !== want.empty || got.count !== want.count) begin
        failures++;
        if (failures <= 10)
          $display("%0t: expected st=%0d pos=%0d head=%0d empty=%0b cnt=%0d, got st=%0d pos=%0d head=%0d empty=%0b cnt=%0d",
                   $realtime, want.status, want.pos, want.head, want.empty, want.count,
                   got.status, got.pos, got.head, got.empty, got.count);
      end
    endfunction

    function bit pending();
      return expected.size() != 0;
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned cycle_count = 0;

  spq_scoreboard sb = new();

  sorted_priority_queue #(.CAPACITY(QueueDepth)) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side: check, then decide tready for the next cycle
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) sb.check_result(m_tdata);
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left   = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_item(input logic [OpW-1:0] op, input logic [KeyW-1:0] key);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= InDataW'({$urandom, $urandom});
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, key, op};
    do @(posedge clk_i); while (!s_tready);
    sb.note_request(op, key);
  endtask

  // sender stops until the queue has answered everything
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending()) @(posedge clk_i);
  endtask

  function automatic logic [OpW-1:0] pick_op(bit grow);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 4) return OP_UNUSED;
    if (r < (grow ? 70 : 25)) return OP_INSERT;
    if (r < (grow ? 82 : 80)) return OP_REMOVE;
    return OP_FIND;
  endfunction

  // mostly keys that are stored or likely duplicates, so finds and removes hit
  function automatic logic [KeyW-1:0] pick_key();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 35 && sb.store.size() > 0) return sb.store[$urandom_range(sb.store.size() - 1)];
    if (sel < 75) return KeyPool[$urandom_range(7)];
    return $urandom;
  endfunction

  initial begin : stimulus
    int unsigned phase;
    int unsigned n;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty queue
    send_item(OP_REMOVE, 32'd5);
    send_item(OP_FIND,   32'd5);
    send_item(OP_UNUSED, 32'd0);
    // extremes, zero, minus one and duplicates
    send_item(OP_INSERT, 32'h7FFF_FFFF);
    send_item(OP_INSERT, 32'h8000_0000);
    send_item(OP_INSERT, 32'h0000_0000);
    send_item(OP_INSERT, 32'hFFFF_FFFF);
    send_item(OP_INSERT, 32'h0000_0000);
    send_item(OP_INSERT, 32'h8000_0000);
    send_item(OP_FIND,   32'h0000_0000);
    send_item(OP_FIND,   32'h8000_0000);
    send_item(OP_FIND,   32'h7FFF_FFFF);
    send_item(OP_FIND,   32'h0000_0001);
    send_item(OP_UNUSED, 32'hFFFF_FFFF);
    send_item(OP_REMOVE, 32'h8000_0000);
    send_item(OP_REMOVE, 32'h7FFF_FFFF);
    send_item(OP_REMOVE, 32'h0000_0000);
    send_item(OP_REMOVE, 32'd12345);
    send_item(OP_FIND,   32'hFFFF_FFFF);
    drain();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 73; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 73; end
        default: begin idle_pct = 27; stall_pct = 27; end
      endcase
      for (n = 0; n < PhaseItems; n++) begin
        // long receiver hold-off while the sender keeps pushing
        if (phase == 0 && n == 100) hold_requests <= hold_requests + 1;
        send_item(pick_op(((n / RunLength) % 2) == 0), pick_key());
      end
      drain();
    end

    repeat (8) @(posedge clk_i);
    if (sb.failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### sorted_priority_queue.f
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/spq_match.sv
rtl/core/sorted_priority_queue.sv
bench/tb_top.sv
